[hw/rtl/rgb_to_hsv_converter_unit_assert.svh]
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// Check an implication in the same cycle, off while reset is high.
`define RHC_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rhc assertion failed");

// Check an implication in the cycle after the condition, also across reset.
`define RHC_ASSERT_NEXT(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("rhc assertion failed");

`endif

[hw/rtl/rhc_pkg.sv]
// Types and constants of the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

   // Hue sector codes, chosen by the largest component
   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   // Hue constants in units of 1/64 degree
   localparam logic [14:0] HUE_GREEN_OFFSET = 15'd7680;
   localparam logic [14:0] HUE_BLUE_OFFSET  = 15'd15360;
   localparam logic [14:0] HUE_FULL_CIRCLE  = 15'd23040;

   // Quotient bits of each divider; the hue divider runs in the last stages
   localparam int unsigned SAT_QUO_BITS = 16;
   localparam int unsigned HUE_QUO_BITS = 12;
   localparam int unsigned HUE_FIRST_STEP = SAT_QUO_BITS - HUE_QUO_BITS;

   // Classify stage: sector, signed difference and extremes
   typedef struct packed {
      logic       valid;
      logic [1:0] sector;
      logic       hue_neg;
      logic [7:0] hue_mag;
      logic [7:0] max_val;
      logic [7:0] delta;
   } class_stage_type;

   // One stage of the two restoring dividers
   typedef struct packed {
      logic        valid;
      logic [1:0]  sector;
      logic        hue_neg;
      logic        grey;
      logic [7:0]  max_val;
      logic [7:0]  delta;
      logic [7:0]  sat_rem;
      logic [15:0] sat_quo;
      logic [7:0]  hue_rem;
      logic [11:0] hue_quo;
   } div_stage_type;

endpackage

`default_nettype wire

[hw/rtl/rgb_to_hsv_converter_unit.sv]
// RGB to HSV converter: top level with classify, scale, divide and finish stages.
//
// Usage: drive req_red_level, req_green_level and req_blue_level and raise
// start; a transaction is taken at every rising edge where start is high and
// busy is low. busy is high only while reset is applied, so a new pixel can
// enter on every clock.
// Each result appears on rsp_hue_angle, rsp_saturation_level and
// rsp_brightness_level for one cycle, marked by rsp_strobe, once its pixel
// has passed the classify, scale, divide and output registers, in the order
// the pixels came in. Throughput is one pixel per clock. The two restoring
// dividers (saturation and hue) retire one quotient bit per stage, over 16
// stages for saturation and the later ones for hue, plus one classify, one
// scale and one output stage. Reset clears every valid bit, so pixels in
// flight are dropped and no result follows. The receiver cannot stall the
// block; results must be taken in the cycle they are shown.
// Hue is in 1/64 degree (0 for grey), saturation is full scale 65535 (0 for
// black), brightness is the largest component.
`default_nettype none

module rgb_to_hsv_converter_unit
   import rhc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_red_level,
   input  wire logic [7:0]  req_green_level,
   input  wire logic [7:0]  req_blue_level,
   output logic             rsp_strobe,
   output logic [14:0]      rsp_hue_angle,
   output logic [15:0]      rsp_saturation_level,
   output logic [7:0]       rsp_brightness_level
);

   localparam int unsigned NUM_STEPS = SAT_QUO_BITS;

   class_stage_type cls_in, cls_ff;
   div_stage_type   div_ff [0:NUM_STEPS];
   div_stage_type   div_in [0:NUM_STEPS];

   logic        out_valid_ff;
   logic [14:0] out_hue_ff,    out_hue_in;
   logic [15:0] out_sat_ff,    out_sat_in;
   logic [7:0]  out_bright_ff;

   logic        accept;
   logic        red_top, green_top;
   logic [7:0]  max_v, min_v;
   logic [8:0]  diff;

   // Refuse transactions only while reset is applied
   assign busy   = reset;
   assign accept = start && !busy;

   // Classify: pick the sector, extremes and signed difference
   always_comb begin
      red_top   = (req_red_level >= req_green_level) && (req_red_level >= req_blue_level);
      green_top = !red_top && (req_green_level >= req_blue_level);
      max_v = req_red_level;
      if (req_green_level > max_v) max_v = req_green_level;
      if (req_blue_level > max_v) max_v = req_blue_level;
      min_v = req_red_level;
      if (req_green_level < min_v) min_v = req_green_level;
      if (req_blue_level < min_v) min_v = req_blue_level;
      if (red_top) begin
         diff = {1'b0, req_green_level} - {1'b0, req_blue_level};
      end else if (green_top) begin
         diff = {1'b0, req_blue_level} - {1'b0, req_red_level};
      end else begin
         diff = {1'b0, req_red_level} - {1'b0, req_green_level};
      end
      cls_in.valid   = accept;
      cls_in.sector  = red_top ? SECTOR_RED : (green_top ? SECTOR_GREEN : SECTOR_BLUE);
      cls_in.hue_neg = diff[8];
      cls_in.hue_mag = diff[8] ? 8'(-diff) : diff[7:0];
      cls_in.max_val = max_v;
      cls_in.delta   = max_v - min_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff <= '0;
      end else begin
         cls_ff <= cls_in;
      end
   end

   // Scale: form delta*65535 and |diff|*3840 by shift and subtract
   logic [23:0] sat_num;
   logic [19:0] hue_num;

   always_comb begin
      sat_num = {cls_ff.delta, 16'd0} - {16'd0, cls_ff.delta};
      hue_num = {cls_ff.hue_mag, 12'd0} - {4'd0, cls_ff.hue_mag, 8'd0};
      div_in[0].valid   = cls_ff.valid;
      div_in[0].sector  = cls_ff.sector;
      div_in[0].hue_neg = cls_ff.hue_neg;
      div_in[0].grey    = (cls_ff.delta == 8'd0);
      div_in[0].max_val = cls_ff.max_val;
      div_in[0].delta   = cls_ff.delta;
      div_in[0].sat_rem = sat_num[23:16];
      div_in[0].sat_quo = sat_num[15:0];
      div_in[0].hue_rem = hue_num[19:12];
      div_in[0].hue_quo = hue_num[11:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0] <= '0;
      end else begin
         div_ff[0] <= div_in[0];
      end
   end

   // Divide: one restoring step per stage for saturation, and for hue in the last stages
   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      logic [8:0] sat_trial, hue_trial;
      logic       sat_ge, hue_ge;

      always_comb begin
         div_in[k+1] = div_ff[k];
         sat_trial = {div_ff[k].sat_rem, div_ff[k].sat_quo[SAT_QUO_BITS-1]};
         sat_ge    = sat_trial >= {1'b0, div_ff[k].max_val};
         div_in[k+1].sat_rem = sat_ge ? 8'(sat_trial - {1'b0, div_ff[k].max_val})
                                      : sat_trial[7:0];
         div_in[k+1].sat_quo = {div_ff[k].sat_quo[SAT_QUO_BITS-2:0], sat_ge};
         hue_trial = {div_ff[k].hue_rem, div_ff[k].hue_quo[HUE_QUO_BITS-1]};
         hue_ge    = hue_trial >= {1'b0, div_ff[k].delta};
         if (k >= HUE_FIRST_STEP) begin
            div_in[k+1].hue_rem = hue_ge ? 8'(hue_trial - {1'b0, div_ff[k].delta})
                                         : hue_trial[7:0];
            div_in[k+1].hue_quo = {div_ff[k].hue_quo[HUE_QUO_BITS-2:0], hue_ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k+1] <= '0;
         end else begin
            div_ff[k+1] <= div_in[k+1];
         end
      end
   end

   // Finish: place the quotient in its sector and wrap negative red hues
   logic [14:0] hue_q;
   logic [14:0] hue_frac;
   logic [14:0] hue_base;

   always_comb begin
      hue_q    = {3'd0, div_ff[NUM_STEPS].hue_quo};
      hue_frac = {14'd0, (div_ff[NUM_STEPS].hue_rem != 8'd0)};
      hue_base = (div_ff[NUM_STEPS].sector == SECTOR_GREEN) ? HUE_GREEN_OFFSET
                                                            : HUE_BLUE_OFFSET;
      if (div_ff[NUM_STEPS].grey) begin
         out_hue_in = 15'd0;
      end else if (div_ff[NUM_STEPS].sector == SECTOR_RED) begin
         if (div_ff[NUM_STEPS].hue_neg && (hue_q != 15'd0)) begin
            out_hue_in = HUE_FULL_CIRCLE - hue_q;
         end else begin
            out_hue_in = hue_q;
         end
      end else if (div_ff[NUM_STEPS].hue_neg) begin
         out_hue_in = hue_base - hue_q - hue_frac;
      end else begin
         out_hue_in = hue_base + hue_q;
      end
      out_sat_in = (div_ff[NUM_STEPS].max_val == 8'd0) ? 16'd0 : div_ff[NUM_STEPS].sat_quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_ff[NUM_STEPS].valid;
      end
      out_hue_ff    <= out_hue_in;
      out_sat_ff    <= out_sat_in;
      out_bright_ff <= div_ff[NUM_STEPS].max_val;
   end

   assign rsp_strobe           = out_valid_ff;
   assign rsp_hue_angle        = out_hue_ff;
   assign rsp_saturation_level = out_sat_ff;
   assign rsp_brightness_level = out_bright_ff;

   // Assertions
`include "rgb_to_hsv_converter_unit_assert.svh"

   `RHC_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_strobe, rsp_hue_angle < HUE_FULL_CIRCLE)
   `RHC_ASSERT_IMPLY(a_black_sat, clock, reset, rsp_strobe && (rsp_brightness_level == 8'd0), rsp_saturation_level == 16'd0)
   `RHC_ASSERT_IMPLY(a_grey_hue, clock, reset, rsp_strobe && (rsp_saturation_level == 16'd0), rsp_hue_angle == 15'd0)
   `RHC_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_strobe && !cls_ff.valid && !div_ff[0].valid)

endmodule

`default_nettype wire

[test/rhc_checker.sv]
// Pixel checker for the RGB to HSV converter: predicts each HSV result and compares it.
module rhc_checker
   import rhc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [7:0]  req_red_level,
   input  wire logic [7:0]  req_green_level,
   input  wire logic [7:0]  req_blue_level,
   input  wire logic        rsp_strobe,
   input  wire logic [14:0] rsp_hue_angle,
   input  wire logic [15:0] rsp_saturation_level,
   input  wire logic [7:0]  rsp_brightness_level,
   output int               error_count,
   output int               pending_count,
   output int               compared_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Hue span of one sector in 1/64 degree, and saturation full scale
   localparam int HUE_SECTOR_SPAN = 3840;
   localparam int SAT_FULL_SCALE  = 65535;
   localparam int REPORT_LIMIT    = 20;

   typedef struct {
      logic [14:0] hue;
      logic [15:0] sat;
      logic [7:0]  bright;
   } hsv_pixel_type;

   hsv_pixel_type expected_hsv[$];
   hsv_pixel_type want;

   // Convert one pixel with plain integer math
   function automatic hsv_pixel_type convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
      hsv_pixel_type px;
      int red, green, blue, top, bottom, spread, base, diff, hue;
      logic [1:0] sector;
      red    = r;
      green  = g;
      blue   = b;
      top    = red;
      bottom = red;
      if (green > top) top = green;
      if (blue > top) top = blue;
      if (green < bottom) bottom = green;
      if (blue < bottom) bottom = blue;
      spread = top - bottom;

      // Ties go to red first, then green
      if (red == top) sector = SECTOR_RED;
      else if (green == top) sector = SECTOR_GREEN;
      else sector = SECTOR_BLUE;

      px.sat = (top == 0) ? 16'd0 : 16'((spread * SAT_FULL_SCALE) / top);

      // Grey and black have no hue
      hue  = 0;
      base = 0;
      diff = 0;
      if (spread != 0) begin
         case (sector)
            SECTOR_RED: begin
               base = 0;
               diff = green - blue;
            end
            SECTOR_GREEN: begin
               base = int'(HUE_GREEN_OFFSET);
               diff = blue - red;
            end
            SECTOR_BLUE: begin
               base = int'(HUE_BLUE_OFFSET);
               diff = red - green;
            end
            default: ;
         endcase
         // Signed int division truncates toward zero; wrap negative angles
         hue = (base * spread + HUE_SECTOR_SPAN * diff) / spread;
         if (hue < 0) hue += int'(HUE_FULL_CIRCLE);
      end
      px.hue    = 15'(hue);
      px.bright = 8'(top);
      return px;
   endfunction

   // Compare results first, then record the transaction taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         expected_hsv.delete();
         error_count    = 0;
         compared_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_hsv.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: result with no pixel pending: hue %0d sat %0d bright %0d",
                           $realtime, rsp_hue_angle, rsp_saturation_level,
                           rsp_brightness_level);
            end else begin
               want = expected_hsv.pop_front();
               compared_count++;
               if (rsp_hue_angle !== want.hue) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: hue mismatch: expected %0d, actual %0d",
                              $realtime, want.hue, rsp_hue_angle);
               end
               if (rsp_saturation_level !== want.sat) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: saturation mismatch: expected %0d, actual %0d",
                              $realtime, want.sat, rsp_saturation_level);
               end
               if (rsp_brightness_level !== want.bright) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: brightness mismatch: expected %0d, actual %0d",
                              $realtime, want.bright, rsp_brightness_level);
               end
            end
         end
         if (start && !busy)
            expected_hsv.push_back(convert_pixel(req_red_level, req_green_level,
                                                 req_blue_level));
      end
      pending_count = expected_hsv.size();
   end

endmodule

[test/rgb_to_hsv_converter_unit_tb.sv]
// Testbench top for the RGB to HSV converter: pixel stimulus, timeout and verdict.
module rgb_to_hsv_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 1730;
   localparam int MODE_STRETCH  = 128;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 40;

   // Sender idle modes
   localparam int GAP_NONE   = 0;
   localparam int GAP_SPARSE = 1;
   localparam int GAP_FULL   = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [7:0]  req_red_level   = 8'd0;
   logic [7:0]  req_green_level = 8'd0;
   logic [7:0]  req_blue_level  = 8'd0;
   logic        busy;
   logic        rsp_strobe;
   logic [14:0] rsp_hue_angle;
   logic [15:0] rsp_saturation_level;
   logic [7:0]  rsp_brightness_level;

   int error_count;
   int pending_count;
   int compared_count;
   int cycle_count = 0;
   int sent_count  = 0;
   int gap_mode    = GAP_FULL;

   rgb_to_hsv_converter_unit uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_red_level        (req_red_level),
      .req_green_level      (req_green_level),
      .req_blue_level       (req_blue_level),
      .rsp_strobe           (rsp_strobe),
      .rsp_hue_angle        (rsp_hue_angle),
      .rsp_saturation_level (rsp_saturation_level),
      .rsp_brightness_level (rsp_brightness_level)
   );

   rhc_checker pixel_check (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_red_level        (req_red_level),
      .req_green_level      (req_green_level),
      .req_blue_level       (req_blue_level),
      .rsp_strobe           (rsp_strobe),
      .rsp_hue_angle        (rsp_hue_angle),
      .rsp_saturation_level (rsp_saturation_level),
      .rsp_brightness_level (rsp_brightness_level),
      .error_count          (error_count),
      .pending_count        (pending_count),
      .compared_count       (compared_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Abort a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d results pending", cycle_count, pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // Idle for the current mode, then hold the pixel until the transaction is taken
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int unsigned gap;
      case (gap_mode)
         GAP_NONE:   gap = 0;
         GAP_SPARSE: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
         default:    gap = $urandom_range(0, 16);
      endcase
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_red_level   <= r;
      req_green_level <= g;
      req_blue_level  <= b;
      do @(posedge clock); while (busy);
      sent_count++;
      @(negedge clock);
   endtask

   // Drop start and hold off until every pending result has come back
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Mostly the ends of the range, sometimes anything
   function automatic logic [7:0] extreme_level();
      case ($urandom_range(0, 4))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd254;
         3:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // A level a few steps from base, clamped to the component range
   function automatic logic [7:0] near_level(input int base);
      int v;
      v = base + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Mix of uniform pixels, tied maxima or minima, near-grey pixels and extremes
   task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                               output logic [7:0] b);
      int unsigned pick;
      int hi, lo;
      pick = $urandom_range(0, 9);
      hi   = $urandom_range(0, 255);
      lo   = $urandom_range(0, hi);
      if (pick < 5) begin
         r = 8'($urandom_range(0, 255));
         g = 8'($urandom_range(0, 255));
         b = 8'($urandom_range(0, 255));
      end else if (pick < 7) begin
         case ($urandom_range(0, 5))
            0:       begin r = 8'(hi); g = 8'(hi); b = 8'(lo); end
            1:       begin r = 8'(hi); g = 8'(lo); b = 8'(hi); end
            2:       begin r = 8'(lo); g = 8'(hi); b = 8'(hi); end
            3:       begin r = 8'(hi); g = 8'(hi); b = 8'(hi); end
            4:       begin r = 8'(lo); g = 8'(lo); b = 8'(hi); end
            default: begin r = 8'(hi); g = 8'(lo); b = 8'(lo); end
         endcase
      end else if (pick < 8) begin
         r = near_level(hi);
         g = near_level(hi);
         b = near_level(hi);
      end else begin
         r = extreme_level();
         g = extreme_level();
         b = extreme_level();
      end
   endtask

   initial begin : stimulus
      logic [7:0] r, g, b;
      int directed_count;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Black, white, grey, primaries, ties and wrap-around hues
      gap_mode = GAP_SPARSE;
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd254, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd254);
      send_pixel(8'd10,  8'd200, 8'd100);
      send_pixel(8'd200, 8'd10,  8'd100);
      send_pixel(8'd170, 8'd85,  8'd255);
      directed_count = sent_count;

      // Let the pipeline empty before random traffic starts
      wait_for_results();

      // Random pixels in stretches of differing idle behavior
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % MODE_STRETCH == 0) gap_mode = $urandom_range(GAP_NONE, GAP_FULL);
         if (i == RANDOM_PIXELS / 2) wait_for_results();
         random_pixel(r, g, b);
         send_pixel(r, g, b);
      end

      // Drain, then watch for stray results
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d pixels (%0d directed), compared %0d results in %0d cycles",
               sent_count, directed_count, compared_count, cycle_count);
      $display("Covered black, grey, primaries, tied maxima and wrapped hues under gapped and",
               " back-to-back traffic");
      if (error_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, pending_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
